// ===== rtl/core/lsdb_pkg.sv =====
package lsdb_pkg;

  localparam int CHANNELS = 4;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;
  localparam int LEVEL_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 1'd1;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

  // water level codes
  localparam logic [LEVEL_W-1:0] LEVEL_EMPTY       = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW         = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM      = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM_HIGH = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH        = 3'd4;

  // per-channel update request from the top level
  typedef struct packed {
    logic load;    // a poll with bus ok is being committed
    logic pin_ok;  // this pin read successfully
    logic wet;     // polarity-corrected reading
  } chan_req_t;

  // encode the stable mask as a water level
  function automatic logic [LEVEL_W-1:0] encode_level(input logic [CHANNELS-1:0] m);
    logic [LEVEL_W-1:0] code;
    if (!m[0]) code = LEVEL_EMPTY;
    else if (!m[1]) code = LEVEL_LOW;
    else if (m[3]) code = LEVEL_HIGH;
    else if (m[2]) code = LEVEL_MEDIUM_HIGH;
    else code = LEVEL_MEDIUM;
    return code;
  endfunction

endpackage

// ===== rtl/core/lsdb_chan.sv =====
module lsdb_chan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lsdb_pkg::chan_req_t         req,
  input  logic [lsdb_pkg::TIME_W-1:0] now_ms,
  input  logic [lsdb_pkg::DEB_W-1:0]  debounce_ms,
  output logic                        stable_wet,
  output logic                        stable_wet_nxt
);
  import lsdb_pkg::*;

  logic              raw_r, raw_nxt;
  logic              stable_r, stable_nxt;
  logic [TIME_W-1:0] change_r, change_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              changed;

  // restart the change time on a new reading, then check the hold time
  always_comb begin
    changed    = req.pin_ok && (req.wet != raw_r);
    raw_nxt    = req.pin_ok ? req.wet : raw_r;
    change_nxt = changed ? now_ms : change_r;
    elapsed    = now_ms - change_nxt;
    stable_nxt = stable_r;
    if (req.pin_ok && (req.wet != stable_r) &&
        (elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms})) begin
      stable_nxt = req.wet;
    end
  end

  // commit only when the request is taken into the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      change_r <= '0;
    end else if (req.load) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      change_r <= change_nxt;
    end
  end

  assign stable_wet     = stable_r;
  assign stable_wet_nxt = stable_nxt;

endmodule

// ===== rtl/core/level_switch_debounce_bank.sv =====
// Four-channel level-switch debouncer with wet/dry polarity and level encode.
// A request passes through the input register, then the result register.
// Throughput: one request per cycle unless the result stalls; the per-pin compare and
// 32-bit wrapping subtract sit between the input register and state/result registers.
// Reset (synchronous, rst_n low): all pins dry, change times zero, level empty,
// unavailable, debounce 50 ms, active high polarity; no result pending.
module level_switch_debounce_bank (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsdb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsdb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_bus_ok,
  input  logic [lsdb_pkg::CHANNELS-1:0]   in_pin_valid,
  input  logic [lsdb_pkg::CHANNELS-1:0]   in_pin_level,
  input  logic [lsdb_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_sensors_available,
  output logic [lsdb_pkg::CHANNELS-1:0]   out_wet_mask,
  output logic [lsdb_pkg::LEVEL_W-1:0]    out_level_code,
  output logic                            out_level_ok
);
  import lsdb_pkg::*;

  logic [DEB_W-1:0]    debounce_r;
  logic                active_low_r;

  logic                s1_valid_r;
  logic                s1_bus_ok_r;
  logic [CHANNELS-1:0] s1_pin_valid_r;
  logic [CHANNELS-1:0] s1_pin_level_r;
  logic [TIME_W-1:0]   s1_now_r;

  logic                out_valid_r;
  logic                avail_r;
  logic [LEVEL_W-1:0]  level_r, level_nxt;

  logic                advance;
  logic                commit;
  logic                load;
  logic [CHANNELS-1:0] wet_now;
  logic [CHANNELS-1:0] stable_mask;
  logic [CHANNELS-1:0] stable_nxt_mask;
  chan_req_t           req [CHANNELS];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      active_low_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS: debounce_r   <= cfg_wdata[DEB_W-1:0];
        CFG_ACTIVE_LOW:  active_low_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake: the result register frees when empty or taken
  assign advance  = !out_valid_r || !out_stall;
  assign commit   = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign load     = commit && s1_bus_ok_r;

  // hold the input request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_bus_ok_r    <= in_bus_ok;
      s1_pin_valid_r <= in_pin_valid;
      s1_pin_level_r <= in_pin_level;
      s1_now_r       <= in_now_ms;
    end
  end

  // map levels to wet by polarity
  assign wet_now = active_low_r ? ~s1_pin_level_r : s1_pin_level_r;

  genvar g;
  generate
    for (g = 0; g < CHANNELS; g++) begin : g_chan
      always_comb begin
        req[g].load   = load;
        req[g].pin_ok = s1_pin_valid_r[g];
        req[g].wet    = wet_now[g];
      end

      lsdb_chan u_chan (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req[g]),
        .now_ms        (s1_now_r),
        .debounce_ms   (debounce_r),
        .stable_wet    (stable_mask[g]),
        .stable_wet_nxt(stable_nxt_mask[g])
      );
    end
  endgenerate

  // encode the level from each channel's next stable value
  assign level_nxt = encode_level(stable_nxt_mask);

  // result register and held level/availability
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      avail_r     <= 1'b0;
      level_r     <= LEVEL_EMPTY;
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (commit) begin
        avail_r <= s1_bus_ok_r;
      end
      if (load) begin
        level_r <= level_nxt;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sensors_available = avail_r;
  assign out_wet_mask          = stable_mask;
  assign out_level_code        = level_r;
  assign out_level_ok          = avail_r && (level_r != LEVEL_EMPTY);

endmodule

// ===== tb/level_switch_debounce_bank_tb.sv =====
`timescale 1ns / 100ps

module level_switch_debounce_bank_tb;
  import lsdb_pkg::*;

  localparam int RUN_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 175;

  // one expected result request
  typedef struct {
    logic                 avail;
    logic [CHANNELS-1:0]  wet;
    logic [LEVEL_W-1:0]   code;
    logic                 ok;
  } level_report_t;

  // tracks debounced switch state and holds the reports still due
  class level_book;
    logic [DEB_W-1:0]    hold_ms;
    logic                low_wet;
    logic [CHANNELS-1:0] raw;
    logic [CHANNELS-1:0] stable;
    logic [TIME_W-1:0]   since [CHANNELS];
    logic [LEVEL_W-1:0]  code;
    logic                avail;
    level_report_t       due [$];
    int                  errors;

    function new();
      hold_ms = DEBOUNCE_RESET;
      low_wet = 1'b0;
      raw = '0;
      stable = '0;
      foreach (since[i]) since[i] = '0;
      code = LEVEL_EMPTY;
      avail = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DEBOUNCE_MS: hold_ms = data[DEB_W-1:0];
        CFG_ACTIVE_LOW: low_wet = data[0];
        default: ;
      endcase
    endfunction

    // map the stable mask to a water level, lowest switch first
    function logic [LEVEL_W-1:0] level_of(logic [CHANNELS-1:0] m);
      casez (m)
        4'b???0: return LEVEL_EMPTY;
        4'b??01: return LEVEL_LOW;
        4'b1?11: return LEVEL_HIGH;
        4'b0111: return LEVEL_MEDIUM_HIGH;
        default: return LEVEL_MEDIUM;
      endcase
    endfunction

    // advance the debounce state by one accepted poll and queue its report
    function void take_poll(logic bus, logic [CHANNELS-1:0] pv, logic [CHANNELS-1:0] lv,
                            logic [TIME_W-1:0] t);
      logic [CHANNELS-1:0] reading;
      logic [TIME_W-1:0]   elapsed;
      level_report_t       rep;
      if (!bus) begin
        avail = 1'b0;
      end else begin
        reading = low_wet ? ~lv : lv;
        avail = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (pv[i]) begin
            if (reading[i] != raw[i]) begin
              raw[i] = reading[i];
              since[i] = t;
            end
            elapsed = t - since[i];
            if (reading[i] != stable[i] && elapsed >= TIME_W'(hold_ms))
              stable[i] = reading[i];
          end
        end
        code = level_of(stable);
      end
      rep.avail = avail;
      rep.wet = stable;
      rep.code = code;
      rep.ok = avail && (code != LEVEL_EMPTY);
      due.push_back(rep);
    endfunction

    // compare one result request against the oldest report due
    function void match_level(logic avail_o, logic [CHANNELS-1:0] wet_o,
                              logic [LEVEL_W-1:0] code_o, logic ok_o);
      level_report_t exp_rep;
      if (due.size() == 0) begin
        $display("%0t: unexpected result avail=%0b wet=%h code=%0d ok=%0b",
                 $time, avail_o, wet_o, code_o, ok_o);
        errors++;
        return;
      end
      exp_rep = due.pop_front();
      if (avail_o !== exp_rep.avail) begin
        $display("%0t: sensors_available expected %0b, got %0b", $time, exp_rep.avail, avail_o);
        errors++;
      end
      if (wet_o !== exp_rep.wet) begin
        $display("%0t: wet_mask expected %h, got %h", $time, exp_rep.wet, wet_o);
        errors++;
      end
      if (code_o !== exp_rep.code) begin
        $display("%0t: level_code expected %0d, got %0d", $time, exp_rep.code, code_o);
        errors++;
      end
      if (ok_o !== exp_rep.ok) begin
        $display("%0t: level_ok expected %0b, got %0b", $time, exp_rep.ok, ok_o);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_bus_ok;
  logic [CHANNELS-1:0]   in_pin_valid;
  logic [CHANNELS-1:0]   in_pin_level;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_sensors_available;
  logic [CHANNELS-1:0]   out_wet_mask;
  logic [LEVEL_W-1:0]    out_level_code;
  logic                  out_level_ok;

  level_book book = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  level_switch_debounce_bank uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_bus_ok             (in_bus_ok),
    .in_pin_valid          (in_pin_valid),
    .in_pin_level          (in_pin_level),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_sensors_available (out_sensors_available),
    .out_wet_mask          (out_wet_mask),
    .out_level_code        (out_level_code),
    .out_level_ok          (out_level_ok)
  );

  always #5 clk = ~clk;

  // stall the result channel at random
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // note accepted polls and check accepted results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      book.take_poll(in_bus_ok, in_pin_valid, in_pin_level, in_now_ms);
    if (rst_n && out_valid && !out_stall)
      book.match_level(out_sensors_available, out_wet_mask, out_level_code, out_level_ok);
  end

  // stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // present one poll request, idling first at random, and hold it until taken
  task automatic poll(logic bus, logic [CHANNELS-1:0] pv, logic [CHANNELS-1:0] lv,
                      logic [TIME_W-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bus_ok <= bus;
    in_pin_valid <= pv;
    in_pin_level <= lv;
    in_now_ms <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, wait for every report due, then let the pipeline drain
  task automatic settle(int extra);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (extra + 1) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    book.set_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random polls: mostly steady time with bouncing pins, some jumps and bus faults
  task automatic run_phase(int n, logic [DEB_W-1:0] hold, logic low, int idle, int stall);
    logic [TIME_W-1:0]   t;
    logic [CHANNELS-1:0] lv;
    logic [CHANNELS-1:0] pv;
    logic                bus;
    int                  step_max;
    int                  r;
    int                  pin;
    settle(SETTLE_CYCLES);
    write_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'(hold));
    write_reg(CFG_ACTIVE_LOW, CFG_DATA_W'(low));
    idle_pct = idle;
    stall_pct = stall;
    step_max = int'(hold) / 4 + 3;
    t = $urandom;
    lv = CHANNELS'($urandom_range(15));
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) settle(0);
      r = $urandom_range(99);
      if (r < 4) t = $urandom;
      else if (r < 7) t = t - $urandom_range(1, 200);
      else if (r >= 10) t = t + $urandom_range(0, step_max);
      r = $urandom_range(99);
      pin = $urandom_range(CHANNELS - 1);
      if (r < 30) lv[pin] = ~lv[pin];
      else if (r < 35) lv = CHANNELS'($urandom_range(15));
      bus = ($urandom_range(99) < 92);
      pv = ($urandom_range(99) < 85) ? 4'hF : 4'($urandom_range(15));
      poll(bus, pv, lv, t);
    end
  endtask

  initial begin
    logic [DEB_W-1:0] hold;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_bus_ok <= 1'b0;
    in_pin_valid <= '0;
    in_pin_level <= '0;
    in_now_ms <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 50 ms hold, high level is wet
    poll(1'b1, 4'hF, 4'hF, 32'd0);
    poll(1'b1, 4'hF, 4'hF, 32'd49);
    poll(1'b1, 4'hF, 4'hF, 32'd50);
    poll(1'b0, 4'h0, 4'h0, 32'd1234);
    poll(1'b1, 4'h0, 4'h0, 32'd60);
    poll(1'b1, 4'h1, 4'hE, 32'd70);
    // time running backwards accepts the differing reading at once
    poll(1'b1, 4'h1, 4'hE, 32'd10);
    poll(1'b1, 4'hF, 4'h7, 32'hFFFF_FFFF);
    poll(1'b1, 4'hF, 4'h7, 32'd48);
    poll(1'b1, 4'hF, 4'h7, 32'd49);

    // zero hold: readings become stable in the same poll
    settle(SETTLE_CYCLES);
    write_reg(CFG_DEBOUNCE_MS, '0);
    write_reg(CFG_ACTIVE_LOW, '0);
    poll(1'b1, 4'hF, 4'h3, 32'd100);
    poll(1'b1, 4'hF, 4'h1, 32'd100);
    poll(1'b1, 4'hF, 4'hB, 32'd100);
    poll(1'b1, 4'hF, 4'h0, 32'd0);
    poll(1'b0, 4'hF, 4'hF, 32'd5);

    // longest hold, low level is wet
    settle(SETTLE_CYCLES);
    write_reg(CFG_DEBOUNCE_MS, 16'hFFFF);
    write_reg(CFG_ACTIVE_LOW, 16'd1);
    poll(1'b1, 4'hF, 4'h0, 32'd1000);
    poll(1'b1, 4'hF, 4'h0, 32'd66534);
    poll(1'b1, 4'hF, 4'h0, 32'd66535);
    poll(1'b1, 4'hA, 4'hF, 32'd70000);
    poll(1'b1, 4'hF, 4'hF, 32'h8000_0000);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: hold = 16'd0;
        1: hold = 16'hFFFF;
        2: hold = DEBOUNCE_RESET;
        3: hold = 16'd1;
        4: hold = DEB_W'($urandom_range(2, 300));
        5: hold = DEB_W'($urandom_range(16'hFFFF));
        6: hold = 16'd7;
        default: hold = 16'hFFFF;
      endcase
      case (p % 4)
        0: run_phase(PHASE_REQUESTS, hold, p[0] ^ p[2], 0, 0);
        1: run_phase(PHASE_REQUESTS, hold, p[0] ^ p[2], 73, 0);
        2: run_phase(PHASE_REQUESTS, hold, p[0] ^ p[2], 0, 73);
        default: run_phase(PHASE_REQUESTS, hold, p[0] ^ p[2], 37, 37);
      endcase
    end

    settle(10);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
